>>> sv/quat_to_rotation_matrix_top_assert.svh
// Assertion macros for the quaternion to rotation matrix block.
// No dependencies; included by modules that carry assertions.
`ifndef QUAT_TO_ROTATION_MATRIX_TOP_ASSERT_SVH
`define QUAT_TO_ROTATION_MATRIX_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define Q2R_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define Q2R_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/q2r_pkg.sv
// Shared constants for the quaternion to rotation matrix block.
// No dependencies.
package q2r_pkg;
    localparam int COMP_W   = 16;       // one quaternion component / matrix element
    localparam int NUM_ELEM = 9;
    localparam int NUM_PROD = 10;
    localparam int D_W      = 33;       // squared length, up to 2^32
    localparam int REM_W    = 34;       // divider remainder after doubling
    localparam int SUM_W    = 35;       // signed numerators
    localparam logic signed [COMP_W-1:0] ELEM_MAX = 16'sh7FFF;
    localparam logic signed [COMP_W-1:0] ELEM_MIN = -16'sh8000;

    // product order
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_WW = 3;
    localparam int P_XY = 4;
    localparam int P_XZ = 5;
    localparam int P_YZ = 6;
    localparam int P_WX = 7;
    localparam int P_WY = 8;
    localparam int P_WZ = 9;
endpackage

>>> sv/quat_to_rotation_matrix_top.sv
// Quaternion to 3x3 rotation matrix, fully pipelined with bit-per-stage division.
// Depends on q2r_pkg and quat_to_rotation_matrix_top_assert.svh.
//
// Usage:
//   s_tdata carries one quaternion per request (x, y, z, w, 16 bits each, signed,
//   FRAC_BITS fraction bits). m_tdata returns the nine matrix elements row by row,
//   m_tuser flags a zero quaternion, for which the identity matrix is returned.
//   Each element is round(num * 2^FRAC_BITS / d), ties away from zero, saturated,
//   so the result does not depend on the quaternion's length.
//   The stages are: input register, products,
//   sums, FRAC_BITS + 2 restoring divide stages (one quotient bit each, nine lanes
//   side by side), then rounding and the output register.
//   Throughput is one request per cycle; the divide chain is the depth of the pipe.
//   All stages advance together whenever the output register is empty or taken,
//   so s_tready is high while the receiver keeps up; when m_tready is low with a
//   result waiting, the whole pipe holds and nothing is lost or repeated.
//   Reset clears every valid bit; data registers are not reset.
`include "quat_to_rotation_matrix_top_assert.svh"

module quat_to_rotation_matrix_top #(
    parameter int FRAC_BITS = 14
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // elem_00, 01, 02, 10, 11, 12, 20, 21, 22
    output logic         m_tuser    // degenerate
);
    localparam int CW    = q2r_pkg::COMP_W;
    localparam int NE    = q2r_pkg::NUM_ELEM;
    localparam int NDIV  = FRAC_BITS + 2;
    localparam int QW    = FRAC_BITS + 2;
    localparam int CMP_W = (QW > 17) ? QW : 17;
    localparam logic [CW-1:0] ONE = (FRAC_BITS >= 15) ? 16'h7FFF : 16'(1 << FRAC_BITS);

    logic adv;

    // input stage
    logic signed [CW-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic                 vin_reg;

    // product stage
    logic signed [31:0] p_reg [0:q2r_pkg::NUM_PROD-1];
    logic               vp_reg;

    // divide stages, index 0 is loaded from the sums
    logic [q2r_pkg::REM_W-1:0] rem_reg [0:NDIV][0:NE-1];
    logic [QW-1:0]             quo_reg [0:NDIV][0:NE-1];
    logic                      neg_reg [0:NDIV][0:NE-1];
    logic [q2r_pkg::D_W-1:0]   d_reg   [0:NDIV];
    logic                      deg_reg [0:NDIV];
    logic                      vd_reg  [0:NDIV];

    logic                      mv_reg;
    logic [143:0]              mdata_reg;
    logic                      mdeg_reg;

    assign adv      = !mv_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = mdeg_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qx_reg <= s_tdata[15:0];
            qy_reg <= s_tdata[31:16];
            qz_reg <= s_tdata[47:32];
            qw_reg <= s_tdata[63:48];
            p_reg[q2r_pkg::P_XX] <= qx_reg * qx_reg;
            p_reg[q2r_pkg::P_YY] <= qy_reg * qy_reg;
            p_reg[q2r_pkg::P_ZZ] <= qz_reg * qz_reg;
            p_reg[q2r_pkg::P_WW] <= qw_reg * qw_reg;
            p_reg[q2r_pkg::P_XY] <= qx_reg * qy_reg;
            p_reg[q2r_pkg::P_XZ] <= qx_reg * qz_reg;
            p_reg[q2r_pkg::P_YZ] <= qy_reg * qz_reg;
            p_reg[q2r_pkg::P_WX] <= qw_reg * qx_reg;
            p_reg[q2r_pkg::P_WY] <= qw_reg * qy_reg;
            p_reg[q2r_pkg::P_WZ] <= qw_reg * qz_reg;
        end
    end

    // sums, sign and magnitude
    logic signed [q2r_pkg::SUM_W-1:0] pe [0:q2r_pkg::NUM_PROD-1];
    logic signed [q2r_pkg::SUM_W-1:0] d_sum;
    logic signed [q2r_pkg::SUM_W-1:0] num [0:NE-1];

    always_comb
    begin
        for (int k = 0; k < q2r_pkg::NUM_PROD; k++)
        begin
            pe[k] = q2r_pkg::SUM_W'(p_reg[k]);
        end
        d_sum  = pe[q2r_pkg::P_XX] + pe[q2r_pkg::P_YY] + pe[q2r_pkg::P_ZZ] + pe[q2r_pkg::P_WW];
        num[0] = d_sum - ((pe[q2r_pkg::P_YY] + pe[q2r_pkg::P_ZZ]) <<< 1);
        num[1] = (pe[q2r_pkg::P_XY] - pe[q2r_pkg::P_WZ]) <<< 1;
        num[2] = (pe[q2r_pkg::P_XZ] + pe[q2r_pkg::P_WY]) <<< 1;
        num[3] = (pe[q2r_pkg::P_XY] + pe[q2r_pkg::P_WZ]) <<< 1;
        num[4] = d_sum - ((pe[q2r_pkg::P_XX] + pe[q2r_pkg::P_ZZ]) <<< 1);
        num[5] = (pe[q2r_pkg::P_YZ] - pe[q2r_pkg::P_WX]) <<< 1;
        num[6] = (pe[q2r_pkg::P_XZ] - pe[q2r_pkg::P_WY]) <<< 1;
        num[7] = (pe[q2r_pkg::P_YZ] + pe[q2r_pkg::P_WX]) <<< 1;
        num[8] = d_sum - ((pe[q2r_pkg::P_XX] + pe[q2r_pkg::P_YY]) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg[0]   <= d_sum[q2r_pkg::D_W-1:0];
            deg_reg[0] <= (d_sum == '0);
            for (int i = 0; i < NE; i++)
            begin
                neg_reg[0][i] <= num[i][q2r_pkg::SUM_W-1];
                rem_reg[0][i] <= num[i][q2r_pkg::SUM_W-1] ?
                                 q2r_pkg::REM_W'(-num[i]) : q2r_pkg::REM_W'(num[i]);
                quo_reg[0][i] <= '0;
            end
        end
    end

    // restoring divide: first stage gives the integer bit, the rest one fraction bit each
    for (genvar j = 0; j < NDIV; j++)
    begin : g_div
        logic [q2r_pkg::REM_W-1:0] trial [0:NE-1];
        logic                      qbit  [0:NE-1];

        always_comb
        begin
            for (int i = 0; i < NE; i++)
            begin
                trial[i] = (j == 0) ? rem_reg[j][i] : (rem_reg[j][i] << 1);
                qbit[i]  = (trial[i] >= q2r_pkg::REM_W'(d_reg[j]));
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_reg[j+1]   <= d_reg[j];
                deg_reg[j+1] <= deg_reg[j];
                for (int i = 0; i < NE; i++)
                begin
                    neg_reg[j+1][i] <= neg_reg[j][i];
                    rem_reg[j+1][i] <= qbit[i] ?
                                       trial[i] - q2r_pkg::REM_W'(d_reg[j]) : trial[i];
                    quo_reg[j+1][i] <= {quo_reg[j][i][QW-2:0], qbit[i]};
                end
            end
        end
    end

    // round half up on the doubled quotient, restore sign, saturate
    logic [QW-1:0]    qr   [0:NE-1];
    logic [CMP_W-1:0] qext [0:NE-1];
    logic [CW-1:0]    elem [0:NE-1];
    logic [143:0]     mdata_next;

    always_comb
    begin
        mdata_next = '0;
        for (int i = 0; i < NE; i++)
        begin
            qr[i]   = (quo_reg[NDIV][i] + QW'(1)) >> 1;
            qext[i] = CMP_W'(qr[i]);
            if (deg_reg[NDIV])
            begin
                elem[i] = (i == 0 || i == 4 || i == 8) ? ONE : '0;
            end
            else if (!neg_reg[NDIV][i])
            begin
                elem[i] = (qext[i] > CMP_W'(32767)) ? q2r_pkg::ELEM_MAX : qext[i][CW-1:0];
            end
            else
            begin
                elem[i] = (qext[i] > CMP_W'(32768)) ? q2r_pkg::ELEM_MIN : -qext[i][CW-1:0];
            end
            mdata_next[i*CW +: CW] = elem[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mdata_reg <= mdata_next;
            mdeg_reg  <= deg_reg[NDIV];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vin_reg <= 1'b0;
            vp_reg  <= 1'b0;
            mv_reg  <= 1'b0;
            for (int j = 0; j <= NDIV; j++)
            begin
                vd_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vin_reg   <= s_tvalid;
            vp_reg    <= vin_reg;
            vd_reg[0] <= vp_reg;
            for (int j = 0; j < NDIV; j++)
            begin
                vd_reg[j+1] <= vd_reg[j];
            end
            mv_reg <= vd_reg[NDIV];
        end
    end

    `Q2R_ASSERT_SAME(a_deg_identity, m_tvalid && m_tuser,
        m_tdata[15:0] == ONE && m_tdata[79:64] == ONE && m_tdata[143:128] == ONE &&
        m_tdata[63:16] == '0 && m_tdata[127:80] == '0,
        "degenerate request must give the identity matrix")
    `Q2R_ASSERT_SAME(a_deg_zero_mag, vd_reg[0] && deg_reg[0],
        rem_reg[0][1] == '0 && rem_reg[0][2] == '0 && rem_reg[0][5] == '0,
        "zero length must give zero numerators")
    `Q2R_ASSERT_NEXT(a_hold_pipe, !adv,
        $stable(vin_reg) && $stable(vp_reg) && $stable(vd_reg[NDIV]) && m_tvalid,
        "pipeline must hold while the output is stalled")
endmodule
